// File: rtl/gtwm_pkg.sv
`default_nettype none
package gtwm_pkg;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 24;
  localparam int LEN_W     = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int PAT_SLOTS = 16;
  localparam int SLOT_W    = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd2;

  // Special characters
  localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] FOLD_DELTA = 8'd32;

  // Byte classes
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_GAP  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Classified byte as it travels from front to back
  typedef struct packed {
    logic              start;
    logic [1:0]        kind;
    logic [BYTE_W-1:0] ch;
  } item_t;

  // Fold A..Z to lower case, everything else unchanged
  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + FOLD_DELTA;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gtwm_front.sv
`default_nettype none
module gtwm_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                text_byte,
  input  wire logic                      stream_start,
  output gtwm_pkg::item_t                item,
  output logic                           item_valid,
  input  wire logic                      item_ready
);
  import gtwm_pkg::*;

  logic  held;
  item_t slot;
  item_t slot_next;

  // Classify the incoming byte
  always_comb begin
    slot_next.start = stream_start;
    slot_next.ch    = fold(text_byte);
    if (text_byte == CH_NUL) begin
      slot_next.kind = KIND_END;
    end else if (text_byte == CH_SPACE || text_byte == CH_TAB || text_byte == CH_NL) begin
      slot_next.kind = KIND_GAP;
    end else begin
      slot_next.kind = KIND_CHAR;
    end
  end

  assign in_ready   = !held || item_ready;
  assign item_valid = held;
  assign item       = slot;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot <= slot_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/gtwm_queue.sv
`default_nettype none
module gtwm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  gtwm_pkg::item_t      push_item,
  input  wire logic            push_valid,
  output logic                 push_ready,
  output gtwm_pkg::item_t      pop_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready
);
  import gtwm_pkg::*;

  localparam int DEPTH = 2;

  item_t      entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push_ready = (fill != 2'(DEPTH));
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(DEPTH))
    else $error("queue fill above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'(DEPTH) && !pop) |=> fill == 2'(DEPTH))
    else $error("queue lost an entry while full");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree when empty");
`endif

endmodule
`default_nettype wire

// File: rtl/gtwm_back.sv
`default_nettype none
module gtwm_back #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [gtwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gtwm_pkg::CFG_W-1:0]        cfg_data,
  input  gtwm_pkg::item_t                        item,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   match_now,
  output logic [gtwm_pkg::COUNT_W-1:0]           match_total,
  output logic                                   stopped
);
  import gtwm_pkg::*;

  localparam int WIN_DEPTH = MAX_PATTERN - 1;
  localparam int SEEN_W    = $clog2(MAX_PATTERN);
  localparam int LW        = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;
  localparam int LEN_CAP   = (MAX_PATTERN < PAT_SLOTS) ? MAX_PATTERN : PAT_SLOTS;
  localparam int CMP_N     = (WIN_DEPTH < PAT_SLOTS - 1) ? WIN_DEPTH : PAT_SLOTS - 1;

  // Configuration registers
  logic [CFG_W-1:0] pat_first;
  logic [CFG_W-1:0] pat_last;
  logic [LEN_W-1:0] pat_len;

  // Stream state
  logic [BYTE_W-1:0]  recent [WIN_DEPTH];
  logic [SEEN_W-1:0]  seen;
  logic [COUNT_W-1:0] count;
  logic               ended;

  logic [BYTE_W-1:0]  pat [PAT_SLOTS];
  logic [BYTE_W-1:0]  tgt [CMP_N];
  logic [LEN_W-1:0]   len_eff;
  logic [LW-1:0]      len_m1;
  logic [SEEN_W-1:0]  seen_base;
  logic [COUNT_W-1:0] count_base;
  logic               ended_base;
  logic               take_char;
  logic               hit;
  logic               window_ok;
  logic [SEEN_W-1:0]  seen_next;
  logic [COUNT_W-1:0] count_next;
  logic               ended_next;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_first <= '0;
      pat_last  <= '0;
      pat_len   <= LEN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAT_FIRST: pat_first <= cfg_data;
        REG_PAT_LAST:  pat_last  <= cfg_data;
        REG_PAT_LEN:   pat_len   <= cfg_data[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Folded pattern characters
  always_comb begin
    for (int k = 0; k < PAT_SLOTS / 2; k++) begin
      pat[k]                 = fold(pat_first[k*BYTE_W +: BYTE_W]);
      pat[k + PAT_SLOTS / 2] = fold(pat_last[k*BYTE_W +: BYTE_W]);
    end
  end

  // Effective length: zero reads as one, clamp to the smaller of MAX_PATTERN and the slot count
  always_comb begin
    if (pat_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (pat_len > LEN_W'(LEN_CAP)) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = pat_len;
    end
    len_m1 = LW'(len_eff) - LW'(1);
  end

  // Window entry k is compared with pattern character len-2-k
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int k = 0; k < CMP_N; k++) begin
      idx    = len_eff - LEN_W'(2) - LEN_W'(k);
      tgt[k] = pat[idx[SLOT_W-1:0]];
    end
  end

  // A start of stream clears the state before this byte
  assign seen_base  = item.start ? '0 : seen;
  assign count_base = item.start ? '0 : count;
  assign ended_base = item.start ? 1'b0 : ended;
  assign take_char  = !ended_base && item.kind == KIND_CHAR;

  // Compare every window position at once
  always_comb begin
    logic [LEN_W-1:0] last_idx;
    last_idx  = len_eff - LEN_W'(1);
    window_ok = 1'b1;
    for (int k = 0; k < CMP_N; k++) begin
      if ((LW'(k) < len_m1) && (recent[k] != tgt[k])) begin
        window_ok = 1'b0;
      end
    end
    hit = take_char && (LW'(seen_base) >= len_m1) &&
          (item.ch == pat[last_idx[SLOT_W-1:0]]) && window_ok;
  end

  // Next state
  always_comb begin
    seen_next  = seen_base;
    count_next = count_base;
    ended_next = ended_base || (!ended_base && item.kind == KIND_END);
    if (take_char && seen_base != SEEN_W'(WIN_DEPTH)) begin
      seen_next = seen_base + SEEN_W'(1);
    end
    if (hit && count_base != COUNT_MAX) begin
      count_next = count_base + COUNT_W'(1);
    end
  end

  assign item_ready = !out_valid || out_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      count     <= '0;
      ended     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        out_valid <= item_valid;
      end
      if (pop) begin
        seen  <= seen_next;
        count <= count_next;
        ended <= ended_next;
      end
    end
  end

  // Character window: newest character in entry 0
  always_ff @(posedge clk) begin
    if (pop && take_char) begin
      recent[0] <= item.ch;
      for (int j = 1; j < WIN_DEPTH; j++) begin
        recent[j] <= recent[j-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (pop) begin
      match_now   <= hit;
      match_total <= count_next;
      stopped     <= ended_next;
    end
  end

`ifndef SYNTHESIS
  a_no_hit_when_ended: assert property (@(posedge clk) disable iff (rst)
    (pop && ended && !item.start) |-> !hit)
    else $error("match reported after end of text");
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (pop && hit && !item.start && count != COUNT_MAX) |=> count == $past(count) + COUNT_W'(1))
    else $error("count did not advance on a match");
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && item.start) |=> count <= COUNT_W'(1))
    else $error("stream start did not clear the count");
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    $past(pop) |-> (match_total == count && stopped == ended))
    else $error("output register disagrees with state");
`endif

endmodule
`default_nettype wire

// File: rtl/gap_tolerant_word_match_counter_top.sv
// Gap-tolerant word match counter.
// Counts overlapping, case-insensitive occurrences of a configured word of
// 1 to 16 characters in a byte stream; space, tab and newline bytes are
// skipped wherever they appear. A zero byte stops counting until a byte
// arrives with stream_start set, which clears window, count and stop flag.
// Input channel: in_valid/in_ready carry text_byte and stream_start.
// Output channel: out_valid/out_ready carry one result per input byte:
// match_now, match_total (saturating at 2^24-1) and stopped.
// Configuration: cfg_write with cfg_index 0/1 loads pattern characters
// 0-7 / 8-15 (character 0 in the low byte), index 2 loads the length.
// Write only while no transaction is in flight.
// Throughput: one byte per cycle while out_ready is high; a classify
// register, a two-entry queue and the result register together hold up to
// four transactions, and the window compare checks all positions at once.
// A byte passes the classify register, the queue and the result register,
// in that order, before out_valid rises for its result.
// When the receiver stalls, the result register holds, the queue fills and
// in_ready drops after the pipeline is full; nothing is dropped.
// Reset clears the stream state, sets the pattern to zeros with length 1.
`default_nettype none
module gap_tolerant_word_match_counter_top #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [gtwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gtwm_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      text_byte,
  input  wire logic                            stream_start,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 match_now,
  output logic [gtwm_pkg::COUNT_W-1:0]         match_total,
  output logic                                 stopped
);
  import gtwm_pkg::*;

  item_t front_item;
  logic  front_valid;
  logic  front_ready;
  item_t back_item;
  logic  back_valid;
  logic  back_ready;

  // Classify stage
  gtwm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .stream_start (stream_start),
    .item         (front_item),
    .item_valid   (front_valid),
    .item_ready   (front_ready)
  );

  // Decoupling queue
  gtwm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (back_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Window match and counting
  gtwm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (back_item),
    .item_valid  (back_valid),
    .item_ready  (back_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .match_now   (match_now),
    .match_total (match_total),
    .stopped     (stopped)
  );

endmodule
`default_nettype wire
